// ===== hw/rtl/dense_prim_mst_weight_assert.svh =====
// assertion macros for the minimum spanning tree weight block
// used by the port checker; needs no other file
`ifndef DENSE_PRIM_MST_WEIGHT_ASSERT_SVH
`define DENSE_PRIM_MST_WEIGHT_ASSERT_SVH

// property checked on every rising edge, off while reset is high
`define DPMW_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dense_prim_mst_weight port check failed");

// property checked on every rising edge, reset included
`define DPMW_CHECK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("dense_prim_mst_weight port check failed");

`endif

// ===== hw/rtl/dpmw_pkg.sv =====
// shared types and constants of the minimum spanning tree weight block
// no dependencies
`default_nettype none

package dpmw_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int VERTEX_W = 7;
   localparam int COST_W = 16;
   localparam int LINK_W = COST_W + 1;
   localparam int WEIGHT_W = 22;

   localparam logic [LINK_W-1:0] NO_EDGE = LINK_W'(1) << COST_W;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam logic [VERTEX_W-1:0] VCOUNT_RESET = VERTEX_W'(64);

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_SOLVE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR1,
      ST_LD_WR2,
      ST_PASS,
      ST_SELECT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic done;
      logic [WEIGHT_W-1:0] tree_weight;
      logic connected;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dpmw_req_if.sv =====
// request channel: edge loads and solve commands
// depends on dpmw_pkg
`default_nettype none

interface dpmw_req_if;
   import dpmw_pkg::*;

   logic valid;
   logic ready;
   logic action;
   logic [VERTEX_W-1:0] vertex_a;
   logic [VERTEX_W-1:0] vertex_b;
   logic [COST_W-1:0] edge_cost;

   modport source(output valid, action, vertex_a, vertex_b, edge_cost, input ready);
   modport sink(input valid, action, vertex_a, vertex_b, edge_cost, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dpmw_rsp_if.sv =====
// response channel: tree weight and connected flag
// depends on dpmw_pkg
`default_nettype none

interface dpmw_rsp_if;
   import dpmw_pkg::*;

   logic valid;
   logic ready;
   logic [WEIGHT_W-1:0] tree_weight;
   logic connected;

   modport source(output valid, tree_weight, connected, input ready);
   modport sink(input valid, tree_weight, connected, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dpmw_ram.sv =====
// simple dual port memory, one write and one registered read per cycle
// no dependencies
`default_nettype none

module dpmw_ram #(
   parameter int Width = 17,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dpmw_core.sv =====
// edge loading, prim passes over the matrix memory and clearing sweep
// depends on dpmw_pkg and dpmw_ram
`default_nettype none

module dpmw_core #(
   parameter int MaxVertices = dpmw_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [$clog2(MaxVertices+1)-1:0]   n_vertices,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_action,
   input  wire logic [dpmw_pkg::VERTEX_W-1:0]      req_vertex_a,
   input  wire logic [dpmw_pkg::VERTEX_W-1:0]      req_vertex_b,
   input  wire logic [dpmw_pkg::COST_W-1:0]        req_edge_cost,
   input  wire logic                               out_free,
   output dpmw_pkg::status_type                    status
);
   import dpmw_pkg::*;

   localparam int IW = $clog2(MaxVertices);
   localparam int CW = $clog2(MaxVertices + 1);
   localparam int AW = 2 * IW;
   localparam int MDEPTH = 1 << AW;

   state_type state_ff, state_in;
   logic [CW-1:0] ctr_ff, ctr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic first_ff, first_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [IW-1:0] sel_ff, sel_in;
   logic [LINK_W-1:0] sel_cost_ff, sel_cost_in;
   logic [CW-1:0] reached_ff, reached_in;
   logic [WEIGHT_W-1:0] sum_ff, sum_in;
   logic [IW-1:0] u_ff, u_in, v_ff, v_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   logic m_wr_en;
   logic [AW-1:0] m_wr_addr, m_rd_addr;
   logic [LINK_W-1:0] m_wr_data, m_rd_data;
   logic b_wr_en;
   logic [IW-1:0] b_wr_addr, b_rd_addr;
   logic [LINK_W:0] b_wr_data, b_rd_data;

   logic accept, edge_ok, pass_issue, cost_less, tree_full, tree_now;
   logic [LINK_W-1:0] new_link;
   logic [WEIGHT_W:0] sum_add;
   logic [CW-1:0] reached_next;

   dpmw_ram #(.Width(LINK_W), .Depth(MDEPTH)) u_matrix (
      .clock(clock), .wr_en(m_wr_en), .wr_addr(m_wr_addr), .wr_data(m_wr_data),
      .rd_addr(m_rd_addr), .rd_data(m_rd_data)
   );

   // best link with the tree membership bit on top
   dpmw_ram #(.Width(LINK_W + 1), .Depth(MaxVertices)) u_best (
      .clock(clock), .wr_en(b_wr_en), .wr_addr(b_wr_addr), .wr_data(b_wr_data),
      .rd_addr(b_rd_addr), .rd_data(b_rd_data)
   );

   assign accept = req_valid && req_ready;
   assign edge_ok = (req_vertex_a != '0) && (32'(req_vertex_a) <= MaxVertices)
                    && (req_vertex_b != '0) && (32'(req_vertex_b) <= MaxVertices)
                    && (req_vertex_a != req_vertex_b);
   assign pass_issue = (state_ff == ST_PASS) && (ctr_ff < n_vertices);
   assign cost_less = {1'b0, cost_ff} < m_rd_data;
   assign new_link = (first_ff || (m_rd_data < b_rd_data[LINK_W-1:0])) ?
                     m_rd_data : b_rd_data[LINK_W-1:0];
   assign tree_now = (!first_ff && b_rd_data[LINK_W]) || (rd_idx_ff == pick_ff);
   assign sum_add = {1'b0, sum_ff} + (WEIGHT_W+1)'(sel_cost_ff[COST_W-1:0]);
   assign reached_next = reached_ff + CW'(1);
   assign tree_full = reached_next == n_vertices;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_SOLVE) state_in = ST_PASS;
               else if (edge_ok) state_in = ST_LD_RD;
            end
         end
         ST_LD_RD: state_in = ST_LD_WR1;
         ST_LD_WR1: begin
            state_in = cost_less ? ST_LD_WR2 : ST_IDLE;
         end
         ST_LD_WR2: state_in = ST_IDLE;
         ST_PASS: begin
            if (!pass_issue && !rd_vld_ff) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (sel_cost_ff == NO_EDGE || tree_full) state_in = ST_FINISH;
            else state_in = ST_PASS;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = state_ff == ST_IDLE;
      status.done = (state_ff == ST_FINISH) && out_free;
      status.tree_weight = sum_ff;
      status.connected = reached_ff == n_vertices;

      ctr_in = ctr_ff;
      clr_in = clr_ff;
      first_in = first_ff;
      pick_in = pick_ff;
      sel_in = sel_ff;
      sel_cost_in = sel_cost_ff;
      reached_in = reached_ff;
      sum_in = sum_ff;
      u_in = u_ff;
      v_in = v_ff;
      cost_in = cost_ff;
      rd_vld_in = pass_issue;
      rd_idx_in = ctr_ff[IW-1:0];

      m_wr_en = 1'b0;
      m_wr_addr = {u_ff, v_ff};
      m_wr_data = {1'b0, cost_ff};
      m_rd_addr = (state_ff == ST_PASS) ? {ctr_ff[IW-1:0], pick_ff} : {u_ff, v_ff};
      b_wr_en = 1'b0;
      b_wr_addr = rd_idx_ff;
      b_wr_data = {tree_now, new_link};
      b_rd_addr = ctr_ff[IW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            m_wr_en = 1'b1;
            m_wr_addr = clr_ff;
            m_wr_data = NO_EDGE;
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            u_in = IW'(32'(req_vertex_a) - 32'd1);
            v_in = IW'(32'(req_vertex_b) - 32'd1);
            cost_in = req_edge_cost;
            ctr_in = '0;
            first_in = 1'b1;
            pick_in = '0;
            sel_cost_in = NO_EDGE;
            reached_in = CW'(1);
            sum_in = '0;
         end
         ST_LD_RD: begin
         end
         ST_LD_WR1: begin
            m_wr_en = cost_less;
         end
         ST_LD_WR2: begin
            m_wr_en = 1'b1;
            m_wr_addr = {v_ff, u_ff};
         end
         ST_PASS: begin
            if (pass_issue) ctr_in = ctr_ff + CW'(1);
            if (rd_vld_ff) begin
               b_wr_en = 1'b1;
               if (!tree_now && (new_link < sel_cost_ff)) begin
                  sel_cost_in = new_link;
                  sel_in = rd_idx_ff;
               end
            end
         end
         ST_SELECT: begin
            if (sel_cost_ff != NO_EDGE) begin
               reached_in = reached_next;
               sum_in = sum_add[WEIGHT_W] ? WEIGHT_MAX : sum_add[WEIGHT_W-1:0];
               pick_in = sel_ff;
            end
            ctr_in = '0;
            first_in = 1'b0;
            sel_cost_in = NO_EDGE;
         end
         ST_FINISH: begin
            clr_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in;
      first_ff <= first_in;
      pick_ff <= pick_in;
      sel_ff <= sel_in;
      sel_cost_ff <= sel_cost_in;
      reached_ff <= reached_in;
      sum_ff <= sum_in;
      u_ff <= u_in;
      v_ff <= v_in;
      cost_ff <= cost_in;
      rd_idx_ff <= rd_idx_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dense_prim_mst_weight.sv =====
// edge load: states LD_RD, LD_WR1 and, when the new cost is lower, LD_WR2; solve for n vertices in use:
//   one pass over the matrix memory per tree vertex, plus the result register
// throughput: one item at a time; after each solve the matrix memory is swept,
//   one entry a cycle over the square of MaxVertices rounded up to a power of two
// reset: synchronous, active high; vertex_count returns to 64 and the same sweep runs
//   before the first transfer is taken
`default_nettype none

module dense_prim_mst_weight #(
   parameter int MaxVertices = dpmw_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   dpmw_req_if.sink                           req_if,
   dpmw_rsp_if.source                         rsp_if,
   input  wire logic                          csr_wr_en,
   input  wire logic [dpmw_pkg::VERTEX_W-1:0] csr_wr_data
);
   import dpmw_pkg::*;

   localparam int CW = $clog2(MaxVertices + 1);

   logic [VERTEX_W-1:0] vertex_count_ff;
   logic [CW-1:0] n_vertices;
   logic rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0] tree_weight_ff, tree_weight_in;
   logic connected_ff, connected_in;
   status_type status;

   always_comb begin
      if (vertex_count_ff == '0) n_vertices = CW'(1);
      else if (32'(vertex_count_ff) > MaxVertices) n_vertices = CW'(MaxVertices);
      else n_vertices = CW'(vertex_count_ff);
   end

   dpmw_core #(.MaxVertices(MaxVertices)) u_core (
      .clock(clock),
      .reset(reset),
      .n_vertices(n_vertices),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .req_action(req_if.action),
      .req_vertex_a(req_if.vertex_a),
      .req_vertex_b(req_if.vertex_b),
      .req_edge_cost(req_if.edge_cost),
      .out_free(!rsp_valid_ff),
      .status(status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      tree_weight_in = tree_weight_ff;
      connected_in = connected_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         tree_weight_in = status.tree_weight;
         connected_in = status.connected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) vertex_count_ff <= csr_wr_data;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tree_weight_ff <= tree_weight_in;
      connected_ff <= connected_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.tree_weight = tree_weight_ff;
   assign rsp_if.connected = connected_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dpmw_checker.sv =====
// port checker for the minimum spanning tree weight block, bound to the top level
// depends on dpmw_pkg and dense_prim_mst_weight_assert.svh
`default_nettype none

`include "dense_prim_mst_weight_assert.svh"

module dpmw_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [dpmw_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   input wire logic                          rsp_connected
);

   // stalled response keeps its payload
   `DPMW_CHECK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tree_weight) && $stable(rsp_connected))

   // a response transfer empties the result register
   `DPMW_CHECK(a_rsp_drop, clock, reset, rsp_valid && rsp_ready |=> !rsp_valid)

   // a new result comes with the clearing sweep already running
   `DPMW_CHECK(a_clear_on_result, clock, reset, $rose(rsp_valid) |-> !req_ready)

   // no transfer is taken right out of reset
   `DPMW_CHECK_ALWAYS(a_sweep_after_reset, clock, $fell(reset) |-> !req_ready)

endmodule

bind dense_prim_mst_weight dpmw_checker u_dpmw_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_tree_weight(rsp_if.tree_weight),
   .rsp_connected(rsp_if.connected)
);

`default_nettype wire

// ===== verif/dpmw_mst_checker.sv =====
// checker for the minimum spanning tree weight block: tracks edge loads and
// register writes, computes each expected tree weight and compares responses
// depends on dpmw_pkg, dpmw_req_if and dpmw_rsp_if
`timescale 1ns / 1ps

module dpmw_mst_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   dpmw_req_if                                req,
   dpmw_rsp_if                                rsp,
   input  wire logic                          csr_wr_en,
   input  wire logic [dpmw_pkg::VERTEX_W-1:0] csr_wr_data,
   output int                                 fail_count,
   output int                                 pending_count
);
   import dpmw_pkg::*;

   localparam int NV = MAX_VERTICES_DEF;

   typedef struct {
      logic [WEIGHT_W-1:0] tree_weight;
      logic                connected;
   } tree_result_type;

   logic [LINK_W-1:0]   edge_cost_mat[NV][NV];
   logic [VERTEX_W-1:0] vcount;
   tree_result_type     tree_results_q[$];

   function automatic void clear_edges();
      foreach (edge_cost_mat[i, j]) edge_cost_mat[i][j] = NO_EDGE;
   endfunction

   function automatic void store_edge(logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b,
                                      logic [COST_W-1:0] cost);
      if (a == 0 || a > NV || b == 0 || b > NV || a == b) return;
      if ({1'b0, cost} < edge_cost_mat[a-1][b-1]) begin
         edge_cost_mat[a-1][b-1] = {1'b0, cost};
         edge_cost_mat[b-1][a-1] = {1'b0, cost};
      end
   endfunction

   function automatic tree_result_type grow_tree();
      tree_result_type   r;
      int                n;
      int                reached;
      int                pick;
      logic [31:0]       sum;
      logic [LINK_W-1:0] pick_cost;
      logic [LINK_W-1:0] best[NV];
      bit                joined[NV];
      n = (vcount == 0) ? 1 : ((vcount > NV) ? NV : int'(vcount));
      sum = 0;
      reached = 1;
      for (int j = 0; j < n; j++) begin
         joined[j] = 0;
         best[j] = edge_cost_mat[0][j];
      end
      joined[0] = 1;
      for (int s = 1; s < n; s++) begin
         pick = 0;
         pick_cost = NO_EDGE;
         for (int j = 0; j < n; j++)
            if (!joined[j] && best[j] < pick_cost) begin
               pick_cost = best[j];
               pick = j;
            end
         if (pick_cost == NO_EDGE) break;
         joined[pick] = 1;
         reached++;
         sum += pick_cost;
         if (sum > WEIGHT_MAX) sum = WEIGHT_MAX;
         for (int j = 0; j < n; j++)
            if (edge_cost_mat[j][pick] < best[j]) best[j] = edge_cost_mat[j][pick];
      end
      r.tree_weight = sum[WEIGHT_W-1:0];
      r.connected = (reached == n);
      return r;
   endfunction

   assign pending_count = tree_results_q.size();

   initial begin
      fail_count = 0;
      vcount = VCOUNT_RESET;
      clear_edges();
   end

   always @(posedge clock) begin
      tree_result_type exp_r;
      if (reset) begin
         vcount = VCOUNT_RESET;
         clear_edges();
      end else begin
         if (csr_wr_en) vcount = csr_wr_data;
         if (req.valid && req.ready) begin
            if (req.action == ACTION_LOAD) begin
               store_edge(req.vertex_a, req.vertex_b, req.edge_cost);
            end else begin
               tree_results_q.push_back(grow_tree());
               clear_edges();
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (tree_results_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transfer: weight %0d connected %0d",
                           rsp.tree_weight, rsp.connected);
            end else begin
               exp_r = tree_results_q.pop_front();
               if (rsp.tree_weight !== exp_r.tree_weight || rsp.connected !== exp_r.connected)
               begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: weight exp %0d got %0d, connected exp %0d got %0d",
                              exp_r.tree_weight, rsp.tree_weight,
                              exp_r.connected, rsp.connected);
               end
            end
         end
      end
   end
endmodule

// ===== verif/testbench.sv =====
// top of the minimum spanning tree weight testbench: clock, reset, edge and
// solve stimulus, register writes and the verdict; needs dpmw_mst_checker
`timescale 1ns / 1ps

module testbench;
   import dpmw_pkg::*;

   localparam int NV = MAX_VERTICES_DEF;
   localparam int SETTLE_CYCLES = 4400;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [VERTEX_W-1:0] csr_wr_data;
   int                  fail_count;
   int                  pending_count;
   int                  sent;
   int                  cur_n;
   bit                  idle_on;

   dpmw_req_if req();
   dpmw_rsp_if rsp();

   dense_prim_mst_weight u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dpmw_mst_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2s;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      rsp.ready <= 0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send(logic act, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b,
                       logic [COST_W-1:0] cost);
      bit rdy;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid <= 1;
      req.action <= act;
      req.vertex_a <= a;
      req.vertex_b <= b;
      req.edge_cost <= cost;
      do begin
         @(negedge clock);
         rdy = req.ready;
         @(posedge clock);
      end while (!rdy);
      sent++;
   endtask

   task automatic write_vcount(logic [VERTEX_W-1:0] v);
      req.valid <= 0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      cur_n = (v == 0) ? 1 : ((v > NV) ? NV : int'(v));
   endtask

   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(0, 3))
         0: return COST_W'($urandom_range(0, 15));
         1: return '1;
         default: return COST_W'($urandom());
      endcase
   endfunction

   function automatic logic [VERTEX_W-1:0] in_graph();
      return VERTEX_W'($urandom_range(1, cur_n));
   endfunction

   task automatic run_graph();
      int loads;
      if (cur_n > 1 && $urandom_range(0, 1)) begin
         for (int k = 2; k <= cur_n; k++)
            send(ACTION_LOAD, VERTEX_W'(k), VERTEX_W'($urandom_range(1, k - 1)), pick_cost());
      end
      loads = $urandom_range(0, (cur_n > 12) ? 30 : 3 * cur_n);
      repeat (loads) begin
         if ($urandom_range(0, 9) < 8)
            send(ACTION_LOAD, in_graph(), in_graph(), pick_cost());
         else
            send(ACTION_LOAD, VERTEX_W'($urandom()), VERTEX_W'($urandom()), pick_cost());
      end
      send(ACTION_SOLVE, VERTEX_W'($urandom()), VERTEX_W'($urandom()), COST_W'($urandom()));
   endtask

   initial begin
      int r;
      idle_on = 1;
      sent = 0;
      cur_n = NV;
      reset <= 1;
      csr_wr_en <= 0;
      csr_wr_data <= '0;
      req.valid <= 0;
      req.action <= ACTION_LOAD;
      req.vertex_a <= '0;
      req.vertex_b <= '0;
      req.edge_cost <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // parallel edges, self-loop, bad endpoints, disconnected at full size
      send(ACTION_LOAD, 1, 2, 0);
      send(ACTION_LOAD, 2, 1, 16'hFFFF);
      send(ACTION_LOAD, 2, 3, 16'hFFFF);
      send(ACTION_LOAD, 3, 3, 1);
      send(ACTION_LOAD, 0, 4, 1);
      send(ACTION_LOAD, 4, 127, 1);
      send(ACTION_LOAD, 64, 1, 5);
      send(ACTION_SOLVE, 0, 0, 0);
      write_vcount(1);
      send(ACTION_SOLVE, 127, 127, 16'hFFFF);
      write_vcount(4);
      send(ACTION_LOAD, 1, 2, 10);
      send(ACTION_LOAD, 2, 3, 10);
      send(ACTION_LOAD, 1, 3, 10);
      send(ACTION_LOAD, 3, 4, 7);
      send(ACTION_LOAD, 5, 1, 1);
      send(ACTION_SOLVE, 0, 0, 0);
      write_vcount(0);
      send(ACTION_LOAD, 1, 2, 3);
      send(ACTION_SOLVE, 0, 0, 0);
      write_vcount(127);
      send(ACTION_LOAD, 1, 64, 9);
      send(ACTION_SOLVE, 0, 0, 0);

      while (sent < 1900) begin
         if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) write_vcount(VERTEX_W'($urandom_range(0, 1)));
            else if (r < 6) write_vcount(VERTEX_W'($urandom_range(65, 127)));
            else if (r < 10) write_vcount(64);
            else if (r < 75) write_vcount(VERTEX_W'($urandom_range(2, 10)));
            else write_vcount(VERTEX_W'($urandom_range(11, 30)));
         end
         if (sent > 1700) idle_on = 0;
         run_graph();
      end
      req.valid <= 0;

      @(posedge clock);
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
